// ===== src/swsnd_pkg.sv =====
`timescale 1ns / 1ps
package swsnd_pkg;

  // Store and field sizes
  localparam int BUFFER_SLOTS = 8;   // power of two: slot index is the low sequence bits
  localparam int SEQ_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = $clog2(BUFFER_SLOTS);
  localparam int WIN_BITS     = 4;
  localparam int SLOTS_BITS   = $clog2(BUFFER_SLOTS + 1);
  localparam int CMP_BITS     = (SEQ_BITS > SLOTS_BITS) ? SEQ_BITS : SLOTS_BITS;
  localparam int DUP_BITS     = 3;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(4);
  localparam logic [DUP_BITS-1:0] DUP_TRIGGER  = DUP_BITS'(4);
  localparam logic [DUP_BITS-1:0] DUP_MAX      = DUP_BITS'(7);

  // Input transaction kinds
  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TIMER = 2'd2;

  // Timer commands
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_RESTART = 2'd2;
  localparam logic [1:0] TMR_STOP    = 2'd3;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_BITS-1:0]     ack_number;
    logic                    ack_intact;
    logic [SEQ_BITS-1:0]     timer_tag;
  } in_item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    send_valid;
    logic                    is_retransmit;
    logic [SEQ_BITS-1:0]     send_seq;
    logic [PAYLOAD_BITS-1:0] send_payload;
    logic [1:0]              timer_action;
    logic [SEQ_BITS-1:0]     timer_seq;
    logic                    window_full;
  } out_item_t;

  typedef struct packed {
    logic empty;    // nothing in flight
    logic waiting;  // window filled and not yet drained
  } win_status_t;

endpackage

// ===== src/swsnd_core.sv =====
`timescale 1ns / 1ps
module swsnd_core import swsnd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  in_item_t            item,
  input  logic [WIN_BITS-1:0] window_size,
  output out_item_t           result,
  output win_status_t         status
);

  logic [SEQ_BITS-1:0]     base_r, base_nxt;
  logic [SEQ_BITS-1:0]     next_r, next_nxt;
  logic [SEQ_BITS-1:0]     last_ack_r, last_ack_nxt;
  logic [DUP_BITS-1:0]     dup_r, dup_nxt;
  logic                    wait_r, wait_nxt;
  logic [PAYLOAD_BITS-1:0] store_r [BUFFER_SLOTS];

  logic [SEQ_BITS-1:0]     in_flight;
  logic [SEQ_BITS-1:0]     ack_off;
  logic [SEQ_BITS-1:0]     next_inc;
  logic [SEQ_BITS-1:0]     ack_inc;
  logic [CMP_BITS-1:0]     eff_win;
  logic [PAYLOAD_BITS-1:0] base_payload;
  logic                    store_we;

  assign in_flight    = next_r - base_r;
  assign ack_off      = item.ack_number - base_r;
  assign next_inc     = next_r + SEQ_BITS'(1);
  assign ack_inc      = item.ack_number + SEQ_BITS'(1);
  assign base_payload = store_r[base_r[SLOT_BITS-1:0]];

  // Clamp the window setting to one..slot count
  always_comb begin
    eff_win = CMP_BITS'(window_size);
    if (window_size == '0) begin
      eff_win = CMP_BITS'(1);
    end else if (CMP_BITS'(window_size) > CMP_BITS'(BUFFER_SLOTS)) begin
      eff_win = CMP_BITS'(BUFFER_SLOTS);
    end
  end

  // Work out one transaction
  always_comb begin
    base_nxt     = base_r;
    next_nxt     = next_r;
    last_ack_nxt = last_ack_r;
    dup_nxt      = dup_r;
    wait_nxt     = wait_r;
    store_we     = 1'b0;
    result       = '0;
    case (item.opcode)
      OP_SEND: begin
        if (CMP_BITS'(in_flight) < eff_win) begin
          store_we          = 1'b1;
          result.accepted   = 1'b1;
          result.send_valid = 1'b1;
          result.send_seq   = next_r;
          result.send_payload = item.payload;
          if (base_r == next_r) begin
            result.timer_action = TMR_START;
            result.timer_seq    = base_r;
          end
          next_nxt = next_inc;
          if (CMP_BITS'(SEQ_BITS'(next_inc - base_r)) == eff_win) begin
            wait_nxt = 1'b1;
          end
        end
      end
      OP_ACK: begin
        // Count receipts of the same acknowledgment, fast retransmit on the fourth (third repeat)
        if (item.ack_number == last_ack_r) begin
          if (dup_r < DUP_MAX) begin
            dup_nxt = dup_r + DUP_BITS'(1);
          end
          if (dup_nxt == DUP_TRIGGER) begin
            result.timer_action = TMR_RESTART;
            result.timer_seq    = ack_inc;
            if (in_flight != '0) begin
              result.send_valid    = 1'b1;
              result.is_retransmit = 1'b1;
              result.send_seq      = base_r;
              result.send_payload  = base_payload;
            end
          end
        end else begin
          last_ack_nxt = item.ack_number;
          dup_nxt      = DUP_BITS'(1);
        end
        // Advance the base on a good acknowledgment inside the window
        if (item.ack_intact && (ack_off < in_flight)) begin
          base_nxt = ack_inc;
          if (ack_inc == next_r) begin
            result.timer_action = TMR_STOP;
            result.timer_seq    = base_r;
            wait_nxt            = 1'b0;
          end else begin
            result.timer_action = TMR_RESTART;
            result.timer_seq    = ack_inc;
          end
        end
      end
      OP_TIMER: begin
        result.timer_action = TMR_RESTART;
        result.timer_seq    = item.timer_tag;
        if (in_flight != '0) begin
          result.send_valid    = 1'b1;
          result.is_retransmit = 1'b1;
          result.send_seq      = base_r;
          result.send_payload  = base_payload;
        end
      end
      default: begin
      end
    endcase
    result.window_full = wait_nxt;
  end

  assign status.empty   = (in_flight == '0);
  assign status.waiting = wait_r;

  // Hold window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      next_r     <= '0;
      last_ack_r <= '1;
      dup_r      <= '0;
      wait_r     <= 1'b0;
    end else if (step_en) begin
      base_r     <= base_nxt;
      next_r     <= next_nxt;
      last_ack_r <= last_ack_nxt;
      dup_r      <= dup_nxt;
      wait_r     <= wait_nxt;
    end
  end

  // Keep sent payloads for resends
  always_ff @(posedge clk) begin
    if (step_en && store_we) begin
      store_r[next_r[SLOT_BITS-1:0]] <= item.payload;
    end
  end

endmodule

// ===== src/sliding_window_sender.sv =====
`timescale 1ns / 1ps
// Sender window for a reliable link: each input transaction is a send request,
// an acknowledgment or a timer expiry, and produces exactly one result
// transaction (send/resend, timer command, window-full flag). The block takes
// one transaction per cycle unless the output side stalls; each one passes an
// input register and an output register, and is worked out into the output
// register once that is free. A result held by a stalled output side holds
// the one waiting input transaction and drops in_ready. The user must write
// the window setting (cfg_wdata, one to eight slots, clamped) with cfg_we
// only while no transaction is in the block; the block itself does not
// enforce this.
module sliding_window_sender import swsnd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [WIN_BITS-1:0] cfg_wdata
);

  logic                in_valid_r;
  in_item_t            in_item_r;
  logic                out_valid_r;
  out_item_t           out_item_r;
  logic [WIN_BITS-1:0] win_r;
  logic                out_free;
  logic                step_en;
  out_item_t           step_result;
  win_status_t         win_status;

  assign out_free  = !out_valid_r || out_ready;
  assign step_en   = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || step_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Hold the window setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      win_r <= cfg_wdata;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  swsnd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (in_item_r),
    .window_size (win_r),
    .result      (step_result),
    .status      (win_status)
  );

  // Register the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  // A waiting window always has packets in flight
  a_wait_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    win_status.waiting |-> !win_status.empty)
    else $error("window waiting with nothing in flight");

  // A held input transaction is not dropped while the output side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r)
    else $error("input transaction lost during stall");

  // A resend is never reported together with a newly accepted packet
  a_resend_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.is_retransmit |-> out_item_r.send_valid && !out_item_r.accepted)
    else $error("malformed resend result");

  // An accepted send request always transmits its packet fresh
  a_accept_sends: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && step_result.accepted |-> step_result.send_valid && !step_result.is_retransmit)
    else $error("accepted request without a send");

endmodule
